/* sv/tmsf_pkg.sv */
// Shared types and constants for the trimmed-mean sample filter.
// Used by tmsf_rank_cell and trimmed_mean_sample_filter; depends on nothing.
package tmsf_pkg;

  localparam int SAMPLE_W          = 12;
  localparam int WINDOW_SAMPLES    = 20;
  localparam int TRIM_EACH_END     = 2;
  localparam int MEAN_SHIFT        = 4;
  localparam int CHANNEL_COUNT_DEF = 4;
  localparam int CHANNEL_W         = 3;
  localparam int SLOT_W            = 5;
  localparam int SUM_W             = SAMPLE_W + $clog2(WINDOW_SAMPLES);

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One word moving between neighboring rank cells.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] data;
  } tmsf_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } tmsf_state_t;

endpackage

/* sv/tmsf_rank_cell.sv */
// One cell of a systolic extreme-value chain: keeps the smallest (or largest)
// word seen since clear and passes the other word to its neighbor. Uses tmsf_pkg.
module tmsf_rank_cell #(
  parameter bit KEEP_MIN = 1'b1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  tmsf_pkg::tmsf_link_t                in_link,
  output tmsf_pkg::tmsf_link_t                out_link,
  output logic [tmsf_pkg::SAMPLE_W-1:0]       held,
  output logic                                full
);
  import tmsf_pkg::*;

  logic keep_new;

  assign keep_new = KEEP_MIN ? (in_link.data < held) : (in_link.data > held);

  always_ff @(posedge clk) begin
    if (rst) begin
      full           <= 1'b0;
      out_link.valid <= 1'b0;
    end else if (clear) begin
      full           <= 1'b0;
      out_link.valid <= 1'b0;
    end else if (in_link.valid) begin
      if (!full) begin
        // first word just fills the cell
        full           <= 1'b1;
        out_link.valid <= 1'b0;
        held           <= in_link.data;
      end else begin
        out_link.valid <= 1'b1;
        if (keep_new) begin
          held          <= in_link.data;
          out_link.data <= held;
        end else begin
          out_link.data <= in_link.data;
        end
      end
    end else begin
      out_link.valid <= 1'b0;
    end
  end

endmodule

/* sv/trimmed_mean_sample_filter.sv */
// Top level of the trimmed-mean sample filter: sample memory, query sequencer,
// low and high rank-cell chains and output register. Uses tmsf_pkg, tmsf_rank_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  input   | in_valid / in_stall  | mode, channel, slot, sample
//  output  | out_valid / out_stall| filtered_value
//
// A store word produces no result.
// A query makes 20 memory reads (one read port), then drains the rank chains,
// then forms the mean into the output register.
// A query on a bad channel skips the scan and drain and returns zero.
// Reset clears the sequencer, chain occupancy and output valid; the memory is not cleared.
// A waiting result does not block new store words; the next query waits for the
// output register only in its finish state.
module trimmed_mean_sample_filter #(
  parameter int CHANNEL_COUNT = tmsf_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [tmsf_pkg::CHANNEL_W-1:0]  channel,
  input  logic [tmsf_pkg::SLOT_W-1:0]     slot,
  input  logic [tmsf_pkg::SAMPLE_W-1:0]   sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tmsf_pkg::SAMPLE_W-1:0]   filtered_value
);
  import tmsf_pkg::*;

  localparam int DEPTH = CHANNEL_COUNT * WINDOW_SAMPLES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(WINDOW_SAMPLES);

  tmsf_state_t state, state_next;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_valid;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       chan_base;
  logic                wr_en;

  logic                in_accept;
  logic                ch_ok;
  logic                slot_ok;
  logic                cells_clear;
  logic                load_out;

  logic [AW-1:0]       scan_base;
  logic [CW-1:0]       scan_cnt;
  logic                drain_cnt;
  logic                bad_q;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    trim_sum;
  logic [SUM_W-1:0]    mid_sum;
  logic [SAMPLE_W-1:0] mean;

  tmsf_link_t          low_link  [TRIM_EACH_END];
  tmsf_link_t          high_link [TRIM_EACH_END];
  logic [SAMPLE_W-1:0] low_held  [TRIM_EACH_END];
  logic [SAMPLE_W-1:0] high_held [TRIM_EACH_END];
  logic [TRIM_EACH_END-1:0] low_full;
  logic [TRIM_EACH_END-1:0] high_full;

  assign in_accept = in_valid && !in_stall;
  assign ch_ok     = (channel != '0) && (32'(channel) <= CHANNEL_COUNT);
  assign slot_ok   = 32'(slot) < WINDOW_SAMPLES;
  assign chan_base = AW'(32'(channel - CHANNEL_W'(1)) * WINDOW_SAMPLES);
  assign wr_addr   = AW'(32'(chan_base) + 32'(slot));
  assign wr_en     = in_accept && (mode == MODE_STORE) && ch_ok && slot_ok;
  assign rd_addr   = AW'(32'(scan_base) + 32'(scan_cnt));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sample;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    cells_clear = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (mode == MODE_QUERY)) begin
          cells_clear = 1'b1;
          state_next  = ch_ok ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_cnt == CW'(WINDOW_SAMPLES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last word to reach the far end of each chain
        if (drain_cnt) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      drain_cnt <= 1'b0;
    end else begin
      rd_valid  <= rd_en;
      drain_cnt <= (state == ST_DRAIN) ? !drain_cnt : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cells_clear) begin
      scan_base <= chan_base;
      scan_cnt  <= '0;
      bad_q     <= !ch_ok;
    end else if (rd_en) begin
      scan_cnt  <= scan_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cells_clear) begin
      acc <= '0;
    end else if (rd_valid) begin
      acc <= acc + SUM_W'(rd_data);
    end
  end

  assign low_link[0]  = '{valid: rd_valid, data: rd_data};
  assign high_link[0] = '{valid: rd_valid, data: rd_data};

  for (genvar i = 0; i < TRIM_EACH_END; i++) begin : g_cell
    if (i < TRIM_EACH_END - 1) begin : g_mid
      tmsf_rank_cell #(.KEEP_MIN(1'b1)) u_low (
        .clk(clk), .rst(rst), .clear(cells_clear),
        .in_link(low_link[i]), .out_link(low_link[i+1]),
        .held(low_held[i]), .full(low_full[i])
      );
      tmsf_rank_cell #(.KEEP_MIN(1'b0)) u_high (
        .clk(clk), .rst(rst), .clear(cells_clear),
        .in_link(high_link[i]), .out_link(high_link[i+1]),
        .held(high_held[i]), .full(high_full[i])
      );
    end else begin : g_last
      // words leaving the last cell are the middle ones: drop them
      tmsf_rank_cell #(.KEEP_MIN(1'b1)) u_low (
        .clk(clk), .rst(rst), .clear(cells_clear),
        .in_link(low_link[i]), .out_link(),
        .held(low_held[i]), .full(low_full[i])
      );
      tmsf_rank_cell #(.KEEP_MIN(1'b0)) u_high (
        .clk(clk), .rst(rst), .clear(cells_clear),
        .in_link(high_link[i]), .out_link(),
        .held(high_held[i]), .full(high_full[i])
      );
    end
  end

  always_comb begin
    trim_sum = '0;
    for (int i = 0; i < TRIM_EACH_END; i++) begin
      trim_sum = trim_sum + SUM_W'(low_held[i]) + SUM_W'(high_held[i]);
    end
  end

  assign mid_sum = acc - trim_sum;
  assign mean    = bad_q ? '0 : mid_sum[MEAN_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_value <= mean;
    end
  end

  a_chains_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && !bad_q |-> (&low_full) && (&high_full))
    else $error("rank chains not full at end of scan");

  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == ST_SCAN)
    else $error("read word outside scan");

  a_trim_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && !bad_q |-> acc >= trim_sum)
    else $error("trimmed words exceed window sum");

endmodule
